// ----- hw/rtl/pta_pkg.sv -----
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants of the peer table: entry layout, status codes,
// register map and the per-entry evaluation result.
// ----------------------------------------------------------------------------
package pta_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int UID_W    = 64;
	localparam int ADDR_W   = 32;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 5;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ADDED     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

	// register index as seen in paddr[2]
	localparam logic REG_AGE_LIMIT = 1'b0;

	localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd5;

	typedef struct packed {
		logic [UID_W-1:0]  uid;
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic live;     // valid and not aged out
		logic expired;  // valid and aged out in this transaction
		logic match;    // live and identifier equal
	} eval_t;

endpackage

// ----- hw/rtl/pta_eval.sv -----
// ----------------------------------------------------------------------------
// pta_eval
// Judges one table entry returned by the memory: aging against the limit and
// identifier compare against the announcement under work.
// ----------------------------------------------------------------------------
module pta_eval (
	input  pta_pkg::entry_t                 entry,
	input  logic                            entry_valid,
	input  logic [pta_pkg::UID_W-1:0]       uid,
	input  logic [pta_pkg::TIME_W-1:0]      now,
	input  logic [pta_pkg::TIME_W-1:0]      age_limit,
	output pta_pkg::eval_t                  result
);
	import pta_pkg::*;

	logic [TIME_W-1:0] age;

	// age wraps modulo 2^32, compared unsigned
	assign age = now - entry.stamp;

	always_comb begin
		result.expired = entry_valid && (age > age_limit);
		result.live    = entry_valid && !result.expired;
		result.match   = result.live && (entry.uid == uid);
	end

endmodule

// ----- hw/rtl/peer_table_with_aging_unit.sv -----
// ----------------------------------------------------------------------------
// peer_table_with_aging_unit
// Table of multicast peers with aging. Each announcement sweeps the table
// once: expired entries are freed, the identifier is looked up, and a hit
// refreshes the time stamp; a miss takes the lowest free slot, else is dropped.
// ----------------------------------------------------------------------------
// Flow: one transaction at a time; a new announcement is accepted only in idle,
//   after the previous result has gone into the result register. The single
//   read port of the entry memory is swept one entry per cycle.
// Reset: entry valid bits clear at once (no clearing pass), age_limit = 5;
//   entry contents stay undefined until written.
// ----------------------------------------------------------------------------
module peer_table_with_aging_unit #(
	parameter int TABLE_ENTRIES = pta_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// announcement channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pta_pkg::UID_W-1:0]          peer_uid,
	input  logic [pta_pkg::ADDR_W-1:0]         peer_addr,
	input  logic [pta_pkg::TIME_W-1:0]         now_seconds,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pta_pkg::STATUS_W-1:0]       status,
	output logic [pta_pkg::SLOT_W-1:0]         slot,
	output logic [pta_pkg::COUNT_W-1:0]        live_count,
	output logic [pta_pkg::COUNT_W-1:0]        expired_count,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pta_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pta_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pta_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import pta_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [TIME_W-1:0] age_limit_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_AGE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RST;
		end else if (cfg_wr) begin
			age_limit_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_AGE_LIMIT) ? age_limit_q : '0;

	// ------------------------------------------------------------------
	// Sequencer state and transaction context
	// ------------------------------------------------------------------
	logic [1:0]         state_q;
	logic [UID_W-1:0]   uid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TIME_W-1:0]  now_q;

	logic [IDX_W-1:0]   rd_idx_q;
	logic               rd_on_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	entry_t             entry_s1;

	logic [CNT_W-1:0]   expired_q;
	logic [CNT_W-1:0]   live_q;
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [ADDR_W-1:0]  hit_addr_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic [TABLE_ENTRIES-1:0] valid_q;

	logic               in_take;
	logic               out_slot_free;
	logic               finish;
	eval_t              ev;

	assign in_ready      = (state_q == ST_IDLE);
	assign in_take       = in_valid && in_ready;
	assign out_slot_free = !out_valid || out_ready;
	assign finish        = (state_q == ST_WRITE) && out_slot_free;

	// ------------------------------------------------------------------
	// Entry memory: one read port for the sweep, one write port at finish
	// ------------------------------------------------------------------
	entry_t            mem [TABLE_ENTRIES];
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	entry_t            mem_wd;

	always_ff @(posedge clk) begin
		if (rd_on_q) begin
			entry_s1 <= mem[rd_idx_q];
		end
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// A hit keeps the stored address and only refreshes the time stamp.
	always_comb begin
		mem_we       = finish && (hit_found_q || free_found_q);
		mem_wa       = hit_found_q ? hit_idx_q : free_idx_q;
		mem_wd.uid   = uid_q;
		mem_wd.addr  = hit_found_q ? hit_addr_q : addr_q;
		mem_wd.stamp = now_q;
	end

	// ------------------------------------------------------------------
	// Per-entry judgment of the word just read
	// ------------------------------------------------------------------
	pta_eval u_eval (
		.entry       (entry_s1),
		.entry_valid (valid_q[idx_s1]),
		.uid         (uid_q),
		.now         (now_q),
		.age_limit   (age_limit_q),
		.result      (ev)
	);

	// ------------------------------------------------------------------
	// Sweep control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_on_q  <= 1'b0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= rd_on_q;
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q  <= ST_SCAN;
						rd_on_q  <= 1'b1;
						rd_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					// advance the read pointer, stop after the last entry
					if (rd_on_q) begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
						if (rd_idx_q == LAST_IDX) begin
							rd_on_q <= 1'b0;
						end
					end
					if (vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// hold until the result register can take the result
					if (out_slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the announcement at accept.
	always_ff @(posedge clk) begin
		if (in_take) begin
			uid_q  <= peer_uid;
			addr_q <= peer_addr;
			now_q  <= now_seconds;
		end
	end

	// Accumulate counts, first hit and first free slot over the sweep.
	// An entry that ages out in this sweep counts as free for the lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expired_q    <= '0;
			live_q       <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (in_take) begin
			expired_q    <= '0;
			live_q       <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (vld_s1) begin
			if (ev.expired) begin
				expired_q <= expired_q + CNT_W'(1);
			end
			if (ev.live) begin
				live_q <= live_q + CNT_W'(1);
			end
			if (ev.match && !hit_found_q) begin
				hit_found_q <= 1'b1;
			end
			if (!ev.live && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && ev.match && !hit_found_q) begin
			hit_idx_q  <= idx_s1;
			hit_addr_q <= entry_s1.addr;
		end
		if (vld_s1 && !ev.live && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// Valid bits: drop aged entries during the sweep, set a new entry at finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (vld_s1 && ev.expired) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (finish && !hit_found_q && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [STATUS_W-1:0]  status_d;
	logic [IDX_W-1:0]     slot_idx;
	logic [IDX_W+3:0]     slot_ext;
	logic [CNT_W-1:0]     live_d;
	logic [CNT_W+4:0]     live_ext;
	logic [CNT_W+4:0]     expired_ext;
	logic                 added;

	always_comb begin
		added = !hit_found_q && free_found_q;
		if (hit_found_q) begin
			status_d = STATUS_REFRESHED;
			slot_idx = hit_idx_q;
		end else if (free_found_q) begin
			status_d = STATUS_ADDED;
			slot_idx = free_idx_q;
		end else begin
			status_d = STATUS_DROPPED;
			slot_idx = '0;
		end
		live_d      = live_q + CNT_W'(added);
		slot_ext    = {4'd0, slot_idx};
		live_ext    = {5'd0, live_d};
		expired_ext = {5'd0, expired_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status        <= status_d;
			slot          <= slot_ext[SLOT_W-1:0];
			live_count    <= live_ext[COUNT_W-1:0];
			expired_count <= expired_ext[COUNT_W-1:0];
		end
	end

endmodule
